// ===== design/lic_pkg.sv =====
// Shared types and constants for the line intersection core.
// No dependencies.
package lic_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_POINT    = 2'd0;
  localparam status_t STATUS_PARALLEL = 2'd1;
  localparam status_t STATUS_SAT      = 2'd2;

  // Per-item flags that ride along the divider pipeline; bit 0 = x lane, bit 1 = y lane.
  typedef struct packed {
    logic [1:0] neg;
    logic [1:0] ovf;
    logic       den_zero;
  } lic_flags_t;

endpackage

// ===== design/lic_mul.sv =====
// Two-stage signed multiplier: operand a is split into halves, partial products
// are registered, then summed. No package dependency.
module lic_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int LW = AW / 2;
  localparam int HW = AW - LW;
  localparam int PW = AW + BW;

  logic signed [LW+BW:0]   lo_r;
  logic signed [HW+BW-1:0] hi_r;
  logic signed [LW:0]      a_lo;
  logic signed [HW-1:0]    a_hi;

  assign a_lo = $signed({1'b0, a[LW-1:0]});
  assign a_hi = $signed(a[AW-1:LW]);

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= a_lo * b;
      hi_r <= a_hi * b;
      p    <= (PW'(hi_r) <<< LW) + PW'(lo_r);
    end
  end

endmodule

// ===== design/line_intersection_core.sv =====
// Line-line intersection in determinant form, fully pipelined with a restoring divider.
// Depends on lic_pkg and lic_mul.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_*     | in  | ax, ay, bx, by_coord, cx, cy, dx, dy            | -
//  m_*     | out | cross_x, cross_y, zero pad                      | status
//
// One transaction accepted per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage for both coordinates.
// rst clears only the valid bits. A stalled output freezes the whole pipeline
// (s_tready drops), so no transaction is lost or repeated.
module line_intersection_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [8*COORD_WIDTH-1:0]              s_tdata,  // ax, ay, bx, by_coord, cx, cy, dx, dy
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,  // cross_x, cross_y
  output logic [1:0]                            m_tuser   // status
);

  localparam int W   = COORD_WIDTH;
  localparam int WA  = W + 1;          // point differences
  localparam int PW  = 2 * W + 1;      // p, q
  localparam int DW  = 2 * W + 3;      // determinant
  localparam int NW  = 3 * W + 3;      // numerators
  localparam int CW  = NW + 1;         // divider compare width
  localparam int QW  = W + 1;          // quotient bits kept
  localparam int QW2 = W + 2;          // quotient after rounding
  localparam int OW  = ((2 * W + 7) / 8) * 8;
  localparam int L   = W + 11;         // pipeline depth

  logic         en;
  logic [L-1:0] vld;

  assign en       = !vld[L-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], s_tvalid};
    end
  end

  // stage 1: unpack and differences
  logic signed [W-1:0] in_x1, in_y1, in_x2, in_y2, in_x3, in_y3, in_x4, in_y4;
  assign in_x1 = s_tdata[0*W +: W];
  assign in_y1 = s_tdata[1*W +: W];
  assign in_x2 = s_tdata[2*W +: W];
  assign in_y2 = s_tdata[3*W +: W];
  assign in_x3 = s_tdata[4*W +: W];
  assign in_y3 = s_tdata[5*W +: W];
  assign in_x4 = s_tdata[6*W +: W];
  assign in_y4 = s_tdata[7*W +: W];

  logic signed [W-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [WA-1:0] a1, b1, c1, d1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= in_x1; y1 <= in_y1; x2 <= in_x2; y2 <= in_y2;
      x3 <= in_x3; y3 <= in_y3; x4 <= in_x4; y4 <= in_y4;
      a1 <= WA'(in_x1) - WA'(in_x2);
      b1 <= WA'(in_y1) - WA'(in_y2);
      c1 <= WA'(in_x3) - WA'(in_x4);
      d1 <= WA'(in_y3) - WA'(in_y4);
    end
  end

  // stages 2-3: first products
  logic signed [2*WA-1:0] ad3, bc3;
  logic signed [2*W-1:0]  x1y2, y1x2, x3y4, y3x4;

  lic_mul #(.AW(WA), .BW(WA)) u_ad (.clk(clk), .en(en), .a(a1), .b(d1), .p(ad3));
  lic_mul #(.AW(WA), .BW(WA)) u_bc (.clk(clk), .en(en), .a(b1), .b(c1), .p(bc3));
  lic_mul #(.AW(W),  .BW(W))  u_p0 (.clk(clk), .en(en), .a(x1), .b(y2), .p(x1y2));
  lic_mul #(.AW(W),  .BW(W))  u_p1 (.clk(clk), .en(en), .a(y1), .b(x2), .p(y1x2));
  lic_mul #(.AW(W),  .BW(W))  u_q0 (.clk(clk), .en(en), .a(x3), .b(y4), .p(x3y4));
  lic_mul #(.AW(W),  .BW(W))  u_q1 (.clk(clk), .en(en), .a(y3), .b(x4), .p(y3x4));

  logic signed [WA-1:0] a2, b2, c2, d2, a3, b3, c3, d3, a4, b4, c4, d4;
  logic signed [DW-1:0] den4, den5, den6, den7;
  logic signed [PW-1:0] p4, q4;

  always_ff @(posedge clk) begin
    if (en) begin
      a2 <= a1; b2 <= b1; c2 <= c1; d2 <= d1;
      a3 <= a2; b3 <= b2; c3 <= c2; d3 <= d2;
      a4 <= a3; b4 <= b3; c4 <= c3; d4 <= d3;
      den4 <= DW'(ad3) - DW'(bc3);
      p4   <= PW'(x1y2) - PW'(y1x2);
      q4   <= PW'(x3y4) - PW'(y3x4);
      den5 <= den4;
      den6 <= den5;
      den7 <= den6;
    end
  end

  // per-lane numerators and divider; lane 0 = x, lane 1 = y
  logic [DW-1:0]      dm8;
  logic [DW-1:0]      dm_s [W+2];
  logic [1:0]         neg8;
  logic               dz8;
  lic_pkg::lic_flags_t flg_s [W+2];
  logic [1:0]         neg7, ovf8;
  logic [1:0]         sat_l;
  logic [W-1:0]       val_l [2];

  always_ff @(posedge clk) begin
    if (en) begin
      dm8           <= den7[DW-1] ? -den7 : den7;
      neg8          <= neg7;
      dz8           <= (den7 == '0);
      dm_s[0]       <= dm8;
      flg_s[0].neg      <= neg8;
      flg_s[0].ovf      <= ovf8;
      flg_s[0].den_zero <= dz8;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [PW+WA-1:0] prod_p, prod_q;
    logic signed [NW-1:0]    num7;
    logic [NW-1:0]           nm8;
    logic [NW-1:0]           rem [W+2];
    logic [QW-1:0]           quo [W+2];

    lic_mul #(.AW(PW), .BW(WA)) u_mp (
      .clk(clk), .en(en), .a(p4), .b((l == 0) ? c4 : d4), .p(prod_p));
    lic_mul #(.AW(PW), .BW(WA)) u_mq (
      .clk(clk), .en(en), .a(q4), .b((l == 0) ? a4 : b4), .p(prod_q));

    assign neg7[l] = num7[NW-1] ^ den7[DW-1];
    assign ovf8[l] = {1'b0, nm8} >= (CW'(dm8) << QW);

    always_ff @(posedge clk) begin
      if (en) begin
        num7   <= NW'(prod_p) - NW'(prod_q);
        nm8    <= num7[NW-1] ? -num7 : num7;
        rem[0] <= nm8;
        quo[0] <= '0;
      end
    end

    for (genvar j = 0; j <= W; j++) begin : g_div
      localparam int SH = W - j;
      logic [CW-1:0] shd;
      logic          ge;
      assign shd = CW'(dm_s[j]) << SH;
      assign ge  = {1'b0, rem[j]} >= shd;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? NW'({1'b0, rem[j]} - shd) : rem[j];
          quo[j+1] <= quo[j] | (QW'(ge) << SH);
        end
      end
    end

    // round half away from zero, then saturate
    logic            rnd;
    logic            sat;
    logic [W-1:0]    val;
    logic [QW2-1:0]  qr, lim, mag, smag;
    always_comb begin
      rnd  = {rem[W+1], 1'b0} >= CW'(dm_s[W+1]);
      qr   = QW2'(quo[W+1]) + QW2'(rnd);
      lim  = (QW2'(1) << (W - 1)) - QW2'(!flg_s[W+1].neg[l]);
      sat  = flg_s[W+1].ovf[l] || (qr > lim);
      mag  = sat ? lim : qr;
      smag = flg_s[W+1].neg[l] ? -mag : mag;
      val  = smag[W-1:0];
    end

    assign sat_l[l] = sat;
    assign val_l[l] = val;
  end

  for (genvar j = 0; j <= W; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        dm_s[j+1]  <= dm_s[j];
        flg_s[j+1] <= flg_s[j];
      end
    end
  end

  // output register
  logic [W-1:0]     cross_x, cross_y;
  lic_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg_s[W+1].den_zero) begin
        cross_x <= '0;
        cross_y <= '0;
        status  <= lic_pkg::STATUS_PARALLEL;
      end else begin
        cross_x <= val_l[0];
        cross_y <= val_l[1];
        status  <= (sat_l != '0) ? lic_pkg::STATUS_SAT : lic_pkg::STATUS_POINT;
      end
    end
  end

  assign m_tdata = OW'({cross_y, cross_x});
  assign m_tuser = status;

endmodule
